>>> sv/bmt_pkg.sv
// Shared types and constants for the block match tracker.
// Depends on nothing; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none
package bmt_pkg;

   localparam int CMD_W   = 2;
   localparam int INDEX_W = 12;
   localparam int KIND_W  = 3;
   localparam int WORD_W  = 32;
   localparam int TOTAL_W = 13;
   localparam int NUM_KINDS = 5;
   localparam int RESET_COUNT = 4096;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 160;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET_MATCH = 2'd0,
      CMD_SET_CSUM  = 2'd1,
      CMD_LOOKUP    = 2'd2,
      CMD_FINALIZE  = 2'd3
   } cmd_type;

   localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_SWEEP = 4'b1000
   } state_type;

   typedef struct packed {
      logic reinit;
      logic capture;
      logic exec;
      logic sweep_step;
      logic clear_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic finalize;
      logic count_zero;
      logic out_free;
      logic sweep_done;
      logic clear_done;
   } ctrl_status_type;

endpackage
`default_nettype wire

>>> sv/bmt_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> sv/bmt_ctrl.sv
// Controller state machine of the block match tracker.
// Depends on bmt_pkg; drives the datapath through command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module bmt_ctrl
   import bmt_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic            csr_write,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = !csr_write;
            if (req_tvalid && !csr_write) begin
               cmd.capture = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.out_free) begin
               cmd.exec = 1'b1;
               if (status.finalize && !status.count_zero) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      if (csr_write) begin
         cmd = '0;
         cmd.reinit = 1'b1;
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/bmt_datapath.sv
// Datapath of the block match tracker: entry memories, totals and result register.
// Depends on bmt_pkg and bmt_ram; steered by bmt_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module bmt_datapath
   import bmt_pkg::*;
#(
   parameter int MAX_BLOCKS = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          cmd,
   output ctrl_status_type            status,
   input  wire logic [CMD_W-1:0]      req_cmd,
   input  wire logic [INDEX_W-1:0]    req_block_index,
   input  wire logic [KIND_W-1:0]     req_kind,
   input  wire logic [WORD_W-1:0]     req_source_block,
   input  wire logic [WORD_W-1:0]     req_checksum,
   input  wire logic [TOTAL_W-1:0]    csr_wdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int CW = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
   localparam int DATA_W = KIND_W + 2 * WORD_W;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);
   localparam logic [CW-1:0] DEF_C =
      (RESET_COUNT > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(RESET_COUNT);

   logic [CW-1:0]      count_ff;
   logic [AW-1:0]      addr_ff;
   cmd_type            cmd_ff;
   logic [AW-1:0]      idx_ff;
   logic [KIND_W-1:0]  kind_ff;
   logic [WORD_W-1:0]  src_ff, crc_ff;
   logic               ok_ff;
   logic [TOTAL_W-1:0] unm_ff, unm_in;
   logic [TOTAL_W-1:0] lit_ff, lit_in;
   logic [TOTAL_W-1:0] kcnt_ff [NUM_KINDS];
   logic [TOTAL_W-1:0] kcnt_in [NUM_KINDS];
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [CW-1:0]      idx_ext, wr_ext;
   logic [DATA_W-1:0]  data_rd, data_wr;
   logic               mark_rd, mark_wr;
   logic               data_we, mark_we;
   logic [AW-1:0]      wr_addr;
   logic               is_match, is_csum, is_fin;
   logic [KIND_W-1:0]  kind_rd, out_kind;
   logic [WORD_W-1:0]  src_rd, crc_rd, out_src, out_crc;
   logic               out_mark;

   assign idx_ext = CW'(req_block_index);
   assign wr_ext = CW'(csr_wdata);
   assign {crc_rd, src_rd, kind_rd} = data_rd;

   assign is_match = ok_ff && (cmd_ff == CMD_SET_MATCH) && (kind_rd == KIND_NONE);
   assign is_csum = ok_ff && (cmd_ff == CMD_SET_CSUM);
   assign is_fin = (cmd_ff == CMD_FINALIZE);

   always_comb begin
      wr_addr = idx_ff;
      data_we = 1'b0;
      mark_we = 1'b0;
      data_wr = is_match ? {crc_rd, src_ff, kind_ff} : {crc_ff, src_rd, kind_rd};
      mark_wr = 1'b0;
      if (cmd.clear_step) begin
         wr_addr = addr_ff;
         data_we = 1'b1;
         mark_we = 1'b1;
         data_wr = '0;
         mark_wr = 1'b1;
      end else if (cmd.sweep_step) begin
         wr_addr = addr_ff;
         mark_we = 1'b1;
      end else if (cmd.exec) begin
         data_we = is_match || is_csum;
         mark_we = is_match;
      end
   end

   bmt_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BLOCKS)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (wr_addr),
      .wr_data (data_wr),
      .rd_en   (cmd.capture),
      .rd_addr (idx_ext[AW-1:0]),
      .rd_data (data_rd)
   );

   bmt_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (wr_addr),
      .wr_data (mark_wr),
      .rd_en   (cmd.capture),
      .rd_addr (idx_ext[AW-1:0]),
      .rd_data (mark_rd)
   );

   always_comb begin
      unm_in = unm_ff;
      lit_in = lit_ff;
      for (int i = 0; i < NUM_KINDS; i++) begin
         kcnt_in[i] = kcnt_ff[i];
         if (is_match && (kind_ff == KIND_W'(i + 1))) begin
            kcnt_in[i] = kcnt_ff[i] + 1'b1;
         end
      end
      if (is_match && mark_rd) begin
         unm_in = unm_ff - 1'b1;
      end
      if (is_fin) begin
         lit_in = lit_ff + unm_ff;
         unm_in = '0;
      end
      out_kind = '0;
      out_src = '0;
      out_crc = '0;
      out_mark = 1'b0;
      if (ok_ff) begin
         out_kind = is_match ? kind_ff : kind_rd;
         out_src = is_match ? src_ff : src_rd;
         out_crc = is_csum ? crc_ff : crc_rd;
         out_mark = mark_rd && !is_match && !is_fin;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= cmd_type'(req_cmd);
         idx_ff <= idx_ext[AW-1:0];
         kind_ff <= req_kind;
         src_ff <= req_source_block;
         crc_ff <= req_checksum;
         ok_ff <= idx_ext < count_ff;
      end
      if (cmd.exec) begin
         rsp_data_ff <= {lit_in, kcnt_in[4], kcnt_in[3], kcnt_in[2], kcnt_in[1],
                         kcnt_in[0], unm_in, out_mark, out_crc, out_src, out_kind,
                         ok_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.reinit) begin
         if (reset) begin
            count_ff <= DEF_C;
            unm_ff <= DEF_C[TOTAL_W-1:0];
         end else begin
            count_ff <= (wr_ext > MAX_C) ? MAX_C : wr_ext;
            unm_ff <= (wr_ext > MAX_C) ? MAX_C[TOTAL_W-1:0] : csr_wdata;
         end
         lit_ff <= '0;
         for (int i = 0; i < NUM_KINDS; i++) begin
            kcnt_ff[i] <= '0;
         end
         addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            unm_ff <= unm_in;
            lit_ff <= lit_in;
            for (int i = 0; i < NUM_KINDS; i++) begin
               kcnt_ff[i] <= kcnt_in[i];
            end
            addr_ff <= '0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.clear_step || cmd.sweep_step) begin
            addr_ff <= addr_ff + 1'b1;
         end
      end
   end

   assign status.finalize = is_fin;
   assign status.count_zero = (count_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign status.sweep_done = ((CW'(addr_ff) + 1'b1) == count_ff);
   assign status.clear_done = (addr_ff == AW'(MAX_BLOCKS - 1));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_exec_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && !cmd.reinit |=> rsp_valid_ff)
      else $error("result not presented after execute");

   a_unmatched_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(unm_ff) <= count_ff)
      else $error("unmatched total exceeds block count");

   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_step |-> (CW'(addr_ff) < count_ff))
      else $error("finalize sweep beyond block count");

endmodule
`default_nettype wire

>>> sv/block_match_tracker.sv
// An item is accepted with its memory read and executed once the result register is free.
// Then the next one is accepted; a finalize with block_count > 0 sweeps the marks first.
// The result register lets a result wait while the next item is accepted.
// Reset is synchronous and active high; after reset and after every configuration write
// a clearing pass over all MAX_BLOCKS entries initializes the table before items are taken.
// Depends on bmt_pkg, bmt_ctrl, bmt_datapath and bmt_ram.
`timescale 1ns / 1ps
`default_nettype none
module block_match_tracker
   import bmt_pkg::*;
#(
   parameter int MAX_BLOCKS = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: block_index[11:0], kind[14:12], source_block[46:15], checksum[78:47].
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: cmd[1:0].
   input  wire logic [CMD_W-1:0]      req_tuser,
   // rsp_tdata: in_range, entry_kind, entry_source, entry_checksum, entry_unmatched,
   // unmatched_total, identity_total, relocate_total, partial_total, zero_total,
   // one_total, literal_total.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [TOTAL_W-1:0]    csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   bmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_write  (csr_valid),
      .status     (status),
      .cmd        (cmd)
   );

   bmt_datapath #(.MAX_BLOCKS(MAX_BLOCKS)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_cmd          (req_tuser),
      .req_block_index  (req_tdata[11:0]),
      .req_kind         (req_tdata[14:12]),
      .req_source_block (req_tdata[46:15]),
      .req_checksum     (req_tdata[78:47]),
      .csr_wdata        (csr_wdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata)
   );

endmodule
`default_nettype wire

>>> sim/block_match_tracker_test.sv
// Self-checking testbench for block_match_tracker: drives command items, predicts every
// response from its own copy of the match table, and checks each response field by field.
// Depends on bmt_pkg and the block_match_tracker RTL.
`timescale 1ns / 1ps
module block_match_tracker_test;
   import bmt_pkg::*;

   typedef struct {
      cmd_type            cmd;
      logic [INDEX_W-1:0] index;
      logic [KIND_W-1:0]  kind;
      logic [WORD_W-1:0]  source;
      logic [WORD_W-1:0]  checksum;
   } command_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] literal_total;
      logic [TOTAL_W-1:0] one_total;
      logic [TOTAL_W-1:0] zero_total;
      logic [TOTAL_W-1:0] partial_total;
      logic [TOTAL_W-1:0] relocate_total;
      logic [TOTAL_W-1:0] identity_total;
      logic [TOTAL_W-1:0] unmatched_total;
      logic               entry_unmatched;
      logic [WORD_W-1:0]  entry_checksum;
      logic [WORD_W-1:0]  entry_source;
      logic [KIND_W-1:0]  entry_kind;
      logic               in_range;
   } entry_report_type;

   localparam int STALL_LIMIT = 30000;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid;
   logic csr_ready;
   logic [TOTAL_W-1:0] csr_wdata;

   block_match_tracker dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the match table.
   logic [KIND_W-1:0]  shadow_kind [RESET_COUNT];
   logic [WORD_W-1:0]  shadow_source [RESET_COUNT];
   logic [WORD_W-1:0]  shadow_checksum [RESET_COUNT];
   logic               shadow_mark [RESET_COUNT];
   logic [TOTAL_W-1:0] shadow_unmatched;
   logic [TOTAL_W-1:0] shadow_kind_count [NUM_KINDS];
   logic [TOTAL_W-1:0] shadow_literal;
   logic [TOTAL_W-1:0] shadow_block_count;

   command_type      pending_commands [$];
   entry_report_type expected_reports [$];
   int  error_count = 0;
   int  send_idle = 0;
   int  recv_idle = 0;
   bit  send_hold = 0;
   int  hold_left = 0;
   int  report_count = 0;
   int  quiet_cycles = 0;

   function automatic void reinit_table(logic [TOTAL_W-1:0] count);
      logic [TOTAL_W-1:0] sat;
      sat = (count > RESET_COUNT) ? TOTAL_W'(RESET_COUNT) : count;
      shadow_block_count = sat;
      for (int i = 0; i < RESET_COUNT; i++) begin
         shadow_kind[i] = KIND_NONE;
         shadow_source[i] = '0;
         shadow_checksum[i] = '0;
         shadow_mark[i] = (i < sat);
      end
      shadow_unmatched = sat;
      for (int k = 0; k < NUM_KINDS; k++) shadow_kind_count[k] = '0;
      shadow_literal = '0;
   endfunction

   function automatic entry_report_type apply_command(command_type c);
      entry_report_type r;
      logic hit;
      hit = {1'b0, c.index} < shadow_block_count;
      if (c.cmd == CMD_SET_MATCH && hit) begin
         if (shadow_kind[c.index] == KIND_NONE) begin
            shadow_kind[c.index] = c.kind;
            shadow_source[c.index] = c.source;
            if (shadow_mark[c.index]) begin
               shadow_mark[c.index] = 1'b0;
               shadow_unmatched = shadow_unmatched - 1'b1;
            end
            if (c.kind >= 1 && c.kind <= 5)
               shadow_kind_count[c.kind-1] = shadow_kind_count[c.kind-1] + 1'b1;
         end
      end else if (c.cmd == CMD_SET_CSUM && hit) begin
         shadow_checksum[c.index] = c.checksum;
      end else if (c.cmd == CMD_FINALIZE) begin
         for (int i = 0; i < shadow_block_count; i++) begin
            if (shadow_mark[i]) begin
               shadow_mark[i] = 1'b0;
               shadow_literal = shadow_literal + 1'b1;
            end
         end
         shadow_unmatched = '0;
      end
      r.in_range = hit;
      r.entry_kind = hit ? shadow_kind[c.index] : '0;
      r.entry_source = hit ? shadow_source[c.index] : '0;
      r.entry_checksum = hit ? shadow_checksum[c.index] : '0;
      r.entry_unmatched = hit ? shadow_mark[c.index] : 1'b0;
      r.unmatched_total = shadow_unmatched;
      r.identity_total = shadow_kind_count[0];
      r.relocate_total = shadow_kind_count[1];
      r.partial_total = shadow_kind_count[2];
      r.zero_total = shadow_kind_count[3];
      r.one_total = shadow_kind_count[4];
      r.literal_total = shadow_literal;
      return r;
   endfunction

   function automatic void compare_field(string name, logic [WORD_W-1:0] want,
                                         logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
         error_count++;
      end
   endfunction

   task automatic queue_command(cmd_type cmd, int index, int kind,
                                logic [WORD_W-1:0] source, logic [WORD_W-1:0] checksum);
      command_type c;
      c.cmd = cmd;
      c.index = index[INDEX_W-1:0];
      c.kind = kind[KIND_W-1:0];
      c.source = source;
      c.checksum = checksum;
      pending_commands.push_back(c);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_commands.size() != 0 || req_tvalid || expected_reports.size() != 0);
   endtask

   task automatic write_block_count(logic [TOTAL_W-1:0] count);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= count;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      reinit_table(count);
   endtask

   task automatic queue_random(int items, int count);
      int roll;
      int index;
      cmd_type cmd;
      for (int n = 0; n < items; n++) begin
         roll = $urandom_range(99);
         if (roll < 45) cmd = CMD_SET_MATCH;
         else if (roll < 65) cmd = CMD_SET_CSUM;
         else if (roll < 97) cmd = CMD_LOOKUP;
         else cmd = CMD_FINALIZE;
         if (count > 0 && $urandom_range(99) < 85)
            index = $urandom_range(count > RESET_COUNT ? RESET_COUNT - 1 : count - 1);
         else
            index = $urandom_range(RESET_COUNT - 1);
         queue_command(cmd, index, $urandom_range(7), $urandom, $urandom);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      command_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            c.cmd = cmd_type'(req_tuser);
            c.index = req_tdata[11:0];
            c.kind = req_tdata[14:12];
            c.source = req_tdata[46:15];
            c.checksum = req_tdata[78:47];
            expected_reports.push_back(apply_command(c));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_commands.size() != 0 && !send_hold
                && $urandom_range(99) >= send_idle) begin
               c = pending_commands.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= c.cmd;
               req_tdata <= {1'b0, c.checksum, c.source, c.kind, c.index};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      entry_report_type got;
      entry_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %0h", $realtime, got);
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               compare_field("in_range", want.in_range, got.in_range);
               compare_field("entry_kind", want.entry_kind, got.entry_kind);
               compare_field("entry_source", want.entry_source, got.entry_source);
               compare_field("entry_checksum", want.entry_checksum, got.entry_checksum);
               compare_field("entry_unmatched", want.entry_unmatched, got.entry_unmatched);
               compare_field("unmatched_total", want.unmatched_total, got.unmatched_total);
               compare_field("identity_total", want.identity_total, got.identity_total);
               compare_field("relocate_total", want.relocate_total, got.relocate_total);
               compare_field("partial_total", want.partial_total, got.partial_total);
               compare_field("zero_total", want.zero_total, got.zero_total);
               compare_field("one_total", want.one_total, got.one_total);
               compare_field("literal_total", want.literal_total, got.literal_total);
            end
            report_count++;
            if (report_count == 120) hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("block_match_tracker test failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      reinit_table(TOTAL_W'(RESET_COUNT));
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle = 24;
      recv_idle = 47;

      queue_command(CMD_SET_MATCH, 0, 1, 32'hFFFF_FFFF, 0);
      queue_command(CMD_SET_MATCH, 4095, 5, 32'h0, 0);
      queue_command(CMD_SET_MATCH, 0, 2, 32'h1234_5678, 0);
      queue_command(CMD_SET_MATCH, 1, 0, 32'hAAAA_5555, 0);
      queue_command(CMD_SET_MATCH, 1, 3, 32'h5555_AAAA, 0);
      queue_command(CMD_SET_MATCH, 2, 4, 32'h1, 0);
      queue_command(CMD_SET_MATCH, 3, 6, 32'h2, 0);
      queue_command(CMD_SET_MATCH, 3, 2, 32'h3, 0);
      queue_command(CMD_SET_MATCH, 2730, 7, 32'h8000_0000, 0);
      queue_command(CMD_SET_MATCH, 1365, 2, 32'h7FFF_FFFF, 0);
      queue_command(CMD_SET_CSUM, 4095, 0, 0, 32'hFFFF_FFFF);
      queue_command(CMD_SET_CSUM, 2, 7, 32'hFFFF_FFFF, 32'h0);
      queue_command(CMD_LOOKUP, 0, 0, 0, 0);
      queue_command(CMD_LOOKUP, 4095, 0, 0, 0);
      queue_command(CMD_FINALIZE, 4095, 0, 0, 0);
      queue_command(CMD_SET_MATCH, 5, 2, 32'hDEAD_BEEF, 0);
      queue_command(CMD_SET_MATCH, 6, 0, 32'h77, 0);
      queue_command(CMD_LOOKUP, 6, 0, 0, 0);
      queue_command(CMD_FINALIZE, 0, 0, 0, 0);
      wait_drained();

      write_block_count(0);
      queue_command(CMD_SET_MATCH, 0, 1, 32'h1, 0);
      queue_command(CMD_SET_CSUM, 4095, 0, 0, 32'h9);
      queue_command(CMD_FINALIZE, 0, 0, 0, 0);
      queue_random(10, 0);

      write_block_count(TOTAL_W'(8191));
      queue_random(200, 4096);
      wait_drained();

      send_hold = 1'b0;
      write_block_count(1);
      send_idle = 47;
      recv_idle = 24;
      queue_random(60, 1);

      write_block_count(37);
      queue_random(100, 37);
      while (pending_commands.size() > 50) @(posedge clock);
      send_hold = 1'b1;
      do @(posedge clock);
      while (req_tvalid || expected_reports.size() != 0);
      send_hold = 1'b0;
      queue_random(150, 37);

      write_block_count(4096);
      send_idle = 0;
      recv_idle = 0;
      queue_random(250, 4096);

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("block_match_tracker test passed");
      else
         $display("block_match_tracker test failed");
      $finish;
   end
endmodule
